### hdl/iss_pkg.sv
// Package with the shared types and constants of the indexed sequence store.
`default_nettype none
package iss_pkg;

  localparam int unsigned CAPACITY = 16;
  localparam int unsigned DATA_W   = 32;
  localparam int unsigned POS_W    = 5;
  localparam int unsigned CNT_W    = 5;

  typedef enum logic [2:0] {
    OP_APPEND      = 3'd0,
    OP_PREPEND     = 3'd1,
    OP_DELETE_LAST = 3'd2,
    OP_DELETE_FST  = 3'd3,
    OP_READ        = 3'd4,
    OP_WRITE       = 3'd5,
    OP_INSERT      = 3'd6,
    OP_DELETE_AT   = 3'd7
  } op_e;

  typedef enum logic [1:0] {
    CELL_HOLD  = 2'd0,
    CELL_WRITE = 2'd1,
    CELL_OPEN  = 2'd2,
    CELL_CLOSE = 2'd3
  } cell_op_e;

  typedef struct packed {
    cell_op_e                  op;
    logic signed [DATA_W-1:0]  word;
  } cell_cmd_t;

endpackage
`default_nettype wire

### hdl/iss_if.sv
// Request and response channel interfaces of the indexed sequence store.
`default_nettype none
interface iss_req_if;
  logic                              valid;
  logic                              ready;
  iss_pkg::op_e                      operation;
  logic [iss_pkg::POS_W-1:0]         position;
  logic signed [iss_pkg::DATA_W-1:0] data_word;

  modport source (output valid, operation, position, data_word, input ready);
  modport sink   (input valid, operation, position, data_word, output ready);
endinterface

interface iss_rsp_if;
  logic                              valid;
  logic                              ready;
  logic                              ok;
  logic signed [iss_pkg::DATA_W-1:0] read_word;
  logic [iss_pkg::CNT_W-1:0]         count;
  logic signed [iss_pkg::DATA_W-1:0] head_word;
  logic signed [iss_pkg::DATA_W-1:0] tail_word;

  modport source (output valid, ok, read_word, count, head_word, tail_word, input ready);
  modport sink   (input valid, ok, read_word, count, head_word, tail_word, output ready);
endinterface
`default_nettype wire

### hdl/iss_cell.sv
// One storage cell of the entry chain: holds one word, loads it or takes a neighbor's.
`default_nettype none
module iss_cell #(
  parameter int unsigned IDX  = 0,
  parameter int unsigned AT_W = 5
) (
  input  wire                              clk_i,
  input  wire  iss_pkg::cell_cmd_t         cmd_i,
  input  wire  [AT_W-1:0]                  at_i,
  input  wire  signed [iss_pkg::DATA_W-1:0] left_i,
  input  wire  signed [iss_pkg::DATA_W-1:0] right_i,
  output logic signed [iss_pkg::DATA_W-1:0] word_o
);

  localparam logic [AT_W-1:0] MY_IDX = AT_W'(IDX);

  logic signed [iss_pkg::DATA_W-1:0] word_q, word_d;

  always_comb begin
    word_d = word_q;
    case (cmd_i.op)
      iss_pkg::CELL_WRITE: begin
        if (MY_IDX == at_i) word_d = cmd_i.word;
      end
      iss_pkg::CELL_OPEN: begin
        // make room: later entries move one place up
        if (MY_IDX == at_i)     word_d = cmd_i.word;
        else if (MY_IDX > at_i) word_d = left_i;
      end
      iss_pkg::CELL_CLOSE: begin
        // drop the entry at the index: later entries move one place down
        if (MY_IDX >= at_i) word_d = right_i;
      end
      default: word_d = word_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    word_q <= word_d;
  end

  assign word_o = word_q;

endmodule
`default_nettype wire

### hdl/indexed_sequence_store.sv
// Top level of the indexed sequence store: request decode, cell chain and result register.
//
// Ordered store of up to CAPACITY signed 32-bit words, kept in a row of cells where
// cell i holds entry i. Each request transaction carries one operation (append,
// prepend, delete last, delete first, read, write, insert or delete at an index);
// a request that is out of range, deletes from an empty store or adds to a full
// store is refused with ok low and leaves the store untouched. Every request gives
// exactly one response transaction with ok, the read value (zero unless a read
// succeeded), the low five bits of the entry count, and the head and tail values
// (zero when empty). At the accepting edge every cell loads, keeps, or takes its left or
// right neighbor's word at once, so insert and delete shift the whole row in that single
// edge; after that the head, tail and read values are selected from the cells into the
// response register once it is free (its previous response taken or none waiting).
// A new request is taken as soon as that register is loaded, even while that response
// still waits, but never while the request before it is still being gathered. No
// clearing pass is needed after reset: the store starts empty.
`default_nettype none
module indexed_sequence_store #(
  parameter int unsigned CAPACITY = iss_pkg::CAPACITY
) (
  input  wire       clk_i,
  input  wire       rst_ni,
  iss_req_if.sink   req_i,
  iss_rsp_if.source rsp_o
);

  localparam int unsigned DW   = iss_pkg::DATA_W;
  localparam int unsigned UW   = $clog2(CAPACITY + 1);
  localparam int unsigned CW   = (UW > iss_pkg::POS_W) ? UW : iss_pkg::POS_W;
  localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

  // ---------------------------------------------------------------------------
  // Control state
  // ---------------------------------------------------------------------------
  logic [CW-1:0] used_q, used_d;
  logic          pend_q;       // cells updated, response not yet gathered
  logic          ok_q;
  logic          rd_en_q;
  logic [CW-1:0] pos_q;

  logic          rsp_valid_q;
  logic          rsp_ok_q;
  logic signed [DW-1:0] rsp_read_q, rsp_head_q, rsp_tail_q;
  logic [iss_pkg::CNT_W-1:0] rsp_count_q;

  logic          accept;
  logic          rsp_load;
  logic [CW-1:0] pos_ext;
  logic          full, empty;
  logic          ok_c;
  iss_pkg::cell_cmd_t cmd;
  logic [CW-1:0] at_c;

  // hold new requests while a response is being gathered
  assign req_i.ready = !pend_q;
  assign accept      = req_i.valid && req_i.ready;
  assign rsp_load    = pend_q && (!rsp_valid_q || rsp_o.ready);

  assign pos_ext = CW'(req_i.position);
  assign full    = (used_q == CAP_C);
  assign empty   = (used_q == '0);

  // ---------------------------------------------------------------------------
  // Request decode: legality, new count and the command broadcast to the cells
  // ---------------------------------------------------------------------------
  always_comb begin
    ok_c     = 1'b0;
    used_d   = used_q;
    cmd.op   = iss_pkg::CELL_HOLD;
    cmd.word = req_i.data_word;
    at_c     = pos_ext;
    case (req_i.operation)
      iss_pkg::OP_APPEND: begin
        ok_c   = !full;
        at_c   = used_q;
        cmd.op = iss_pkg::CELL_WRITE;
        used_d = used_q + CW'(1);
      end
      iss_pkg::OP_PREPEND: begin
        ok_c   = !full;
        at_c   = '0;
        cmd.op = iss_pkg::CELL_OPEN;
        used_d = used_q + CW'(1);
      end
      iss_pkg::OP_DELETE_LAST: begin
        ok_c   = !empty;
        used_d = used_q - CW'(1);
      end
      iss_pkg::OP_DELETE_FST: begin
        ok_c   = !empty;
        at_c   = '0;
        cmd.op = iss_pkg::CELL_CLOSE;
        used_d = used_q - CW'(1);
      end
      iss_pkg::OP_READ: begin
        ok_c = (pos_ext < used_q);
      end
      iss_pkg::OP_WRITE: begin
        ok_c   = (pos_ext < used_q);
        cmd.op = iss_pkg::CELL_WRITE;
      end
      iss_pkg::OP_INSERT: begin
        ok_c   = !full && (pos_ext <= used_q);
        cmd.op = iss_pkg::CELL_OPEN;
        used_d = used_q + CW'(1);
      end
      iss_pkg::OP_DELETE_AT: begin
        ok_c   = (pos_ext < used_q);
        cmd.op = iss_pkg::CELL_CLOSE;
        used_d = used_q - CW'(1);
      end
      default: ok_c = 1'b0;
    endcase
    // refused or idle: drop the command, keep the count
    if (!(accept && ok_c)) begin
      cmd.op = iss_pkg::CELL_HOLD;
      used_d = used_q;
    end
  end

  // ---------------------------------------------------------------------------
  // Cell chain
  // ---------------------------------------------------------------------------
  logic signed [DW-1:0] cell_word [CAPACITY];

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic signed [DW-1:0] left_w, right_w;
    if (g == 0) begin : g_first
      assign left_w = '0;
    end else begin : g_mid_l
      assign left_w = cell_word[g-1];
    end
    if (g == CAPACITY - 1) begin : g_last
      assign right_w = cell_word[g];
    end else begin : g_mid_r
      assign right_w = cell_word[g+1];
    end

    iss_cell #(
      .IDX  (g),
      .AT_W (CW)
    ) u_cell (
      .clk_i   (clk_i),
      .cmd_i   (cmd),
      .at_i    (at_c),
      .left_i  (left_w),
      .right_i (right_w),
      .word_o  (cell_word[g])
    );
  end

  // ---------------------------------------------------------------------------
  // Response gather: one-hot select of tail and read cells from the updated row
  // ---------------------------------------------------------------------------
  logic [CW-1:0]        tail_idx;
  logic signed [DW-1:0] tail_sel, read_sel;

  assign tail_idx = used_q - CW'(1);

  always_comb begin
    tail_sel = '0;
    read_sel = '0;
    for (int unsigned k = 0; k < CAPACITY; k++) begin
      if (tail_idx == CW'(k)) tail_sel = tail_sel | cell_word[k];
      if (pos_q == CW'(k))    read_sel = read_sel | cell_word[k];
    end
  end

  // ---------------------------------------------------------------------------
  // Registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q      <= '0;
      pend_q      <= 1'b0;
      rsp_valid_q <= 1'b0;
    end else begin
      used_q <= used_d;
      if (accept)        pend_q <= 1'b1;
      else if (rsp_load) pend_q <= 1'b0;
      if (rsp_load)          rsp_valid_q <= 1'b1;
      else if (rsp_o.ready)  rsp_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      ok_q    <= ok_c;
      rd_en_q <= ok_c && (req_i.operation == iss_pkg::OP_READ);
      pos_q   <= pos_ext;
    end
    if (rsp_load) begin
      rsp_ok_q    <= ok_q;
      rsp_read_q  <= rd_en_q ? read_sel : '0;
      rsp_count_q <= used_q[iss_pkg::CNT_W-1:0];
      rsp_head_q  <= (used_q != '0) ? cell_word[0] : '0;
      rsp_tail_q  <= (used_q != '0) ? tail_sel : '0;
    end
  end

  assign rsp_o.valid     = rsp_valid_q;
  assign rsp_o.ok        = rsp_ok_q;
  assign rsp_o.read_word = rsp_read_q;
  assign rsp_o.count     = rsp_count_q;
  assign rsp_o.head_word = rsp_head_q;
  assign rsp_o.tail_word = rsp_tail_q;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_used_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    used_q <= CAP_C)
    else $error("entry count exceeds capacity");

  a_refused_keeps_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && !ok_c) |=> $stable(used_q))
    else $error("refused request changed the count");

  a_accept_pends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> pend_q && !req_i.ready)
    else $error("accepted request not held for response gather");

  a_load_gives_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_load |=> rsp_valid_q && !pend_q)
    else $error("response load lost");

endmodule
`default_nettype wire

### verif/iss_checker.sv
// Scoreboard for the indexed sequence store: predicts every response and compares it.
module iss_checker
  import iss_pkg::*;
(
  input  wire         clk_i,
  input  wire         rst_ni,
  iss_req_if          req,
  iss_rsp_if          rsp,
  output int unsigned mismatches_o,
  output int unsigned pending_o,
  output int unsigned fill_o,
  output int unsigned replies_o,
  output int unsigned full_hits_o,
  output int unsigned empty_hits_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic                     ok;
    logic signed [DATA_W-1:0] read_word;
    logic [CNT_W-1:0]         count;
    logic signed [DATA_W-1:0] head_word;
    logic signed [DATA_W-1:0] tail_word;
  } status_t;

  logic signed [DATA_W-1:0] seq_words [CAPACITY];
  int unsigned              seq_len = 0;
  status_t                  predicted_status_q [$];
  status_t                  got, want;

  // Apply one request to the shadow sequence and return the status it should report.
  function automatic status_t apply_request(op_e op, logic [POS_W-1:0] pos,
                                            logic signed [DATA_W-1:0] word);
    status_t     st;
    int unsigned at;
    bit          full;
    st   = '0;
    at   = pos;
    full = (seq_len >= CAPACITY);
    case (op)
      OP_APPEND: begin
        if (!full) begin
          seq_words[seq_len] = word;
          seq_len++;
          st.ok = 1'b1;
        end
      end
      OP_PREPEND, OP_INSERT: begin
        if (op == OP_PREPEND) at = 0;
        if (!full && at <= seq_len) begin
          for (int i = seq_len; i > at; i--) seq_words[i] = seq_words[i-1];
          seq_words[at] = word;
          seq_len++;
          st.ok = 1'b1;
        end
      end
      OP_DELETE_LAST: begin
        if (seq_len > 0) begin
          seq_len--;
          st.ok = 1'b1;
        end
      end
      OP_DELETE_FST, OP_DELETE_AT: begin
        if (op == OP_DELETE_FST) at = 0;
        if (at < seq_len) begin
          for (int i = at; i + 1 < seq_len; i++) seq_words[i] = seq_words[i+1];
          seq_len--;
          st.ok = 1'b1;
        end
      end
      OP_READ: begin
        if (at < seq_len) begin
          st.read_word = seq_words[at];
          st.ok        = 1'b1;
        end
      end
      OP_WRITE: begin
        if (at < seq_len) begin
          seq_words[at] = word;
          st.ok         = 1'b1;
        end
      end
      default: ;
    endcase
    st.count = CNT_W'(seq_len);
    if (seq_len > 0) begin
      st.head_word = seq_words[0];
      st.tail_word = seq_words[seq_len-1];
    end
    return st;
  endfunction

  task automatic check_field(string name, logic [DATA_W-1:0] exp_val,
                             logic [DATA_W-1:0] act_val);
    if (act_val !== exp_val) begin
      $error("%s mismatch: expected 0x%08h, actual 0x%08h", name, exp_val, act_val);
      mismatches_o++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      predicted_status_q.delete();
      seq_len      = 0;
      mismatches_o = 0;
      replies_o    = 0;
      full_hits_o  = 0;
      empty_hits_o = 0;
      pending_o    <= 0;
      fill_o       <= 0;
    end else begin
      // Retire the response first: it always belongs to an older request.
      if (rsp.valid && rsp.ready) begin
        replies_o++;
        got = '{rsp.ok, rsp.read_word, rsp.count, rsp.head_word, rsp.tail_word};
        if (predicted_status_q.size() == 0) begin
          $error("response transaction with no request outstanding");
          mismatches_o++;
        end else begin
          want = predicted_status_q.pop_front();
          check_field("ok",        DATA_W'(want.ok),    DATA_W'(got.ok));
          check_field("read_word", want.read_word,      got.read_word);
          check_field("count",     DATA_W'(want.count), DATA_W'(got.count));
          check_field("head_word", want.head_word,      got.head_word);
          check_field("tail_word", want.tail_word,      got.tail_word);
        end
      end
      if (req.valid && req.ready) begin
        if (seq_len == CAPACITY) full_hits_o++;
        if (seq_len == 0) empty_hits_o++;
        predicted_status_q.push_back(apply_request(req.operation, req.position,
                                                   req.data_word));
      end
      pending_o <= predicted_status_q.size();
      fill_o    <= seq_len;
    end
  end

endmodule

### verif/tb.sv
// Top of the indexed sequence store testbench: clock, reset, stimulus and verdict.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import iss_pkg::*;

  // Random requests after the directed opening, and how many of them run without idling.
  localparam int unsigned RANDOM_ITEMS   = 1430;
  localparam int unsigned QUIET_ITEMS    = 150;
  // Allow a generous drain at the end.
  localparam int unsigned DRAIN_CYCLES   = 16;
  // Longest legal silence is one source gap plus one sink stall plus the latency.
  localparam int unsigned WATCHDOG_LIMIT = 2000;

  typedef enum int {
    TREND_GROW,
    TREND_SHRINK,
    TREND_MIXED
  } trend_e;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  bit          source_idles = 1'b1;
  bit          sink_idles   = 1'b1;
  bit          quiet_tail   = 1'b0;
  int unsigned issued       = 0;
  int unsigned idle_cycles  = 0;

  int unsigned mismatches, pending, fill, replies, full_hits, empty_hits;

  iss_req_if req_if ();
  iss_rsp_if rsp_if ();

  indexed_sequence_store dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  iss_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req          (req_if),
    .rsp          (rsp_if),
    .mismatches_o (mismatches),
    .pending_o    (pending),
    .fill_o       (fill),
    .replies_o    (replies),
    .full_hits_o  (full_hits),
    .empty_hits_o (empty_hits)
  );

  always #4 clk_i = ~clk_i;

  // Send one request transaction, with an occasional idle burst in front of it,
  // and hold it until the block takes it.
  task automatic issue(op_e op, logic [POS_W-1:0] pos, logic signed [DATA_W-1:0] word);
    if (source_idles && !quiet_tail && $urandom_range(0, 4) == 0) begin
      req_if.valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk_i);
    end
    req_if.valid     <= 1'b1;
    req_if.operation <= op;
    req_if.position  <= pos;
    req_if.data_word <= word;
    do @(posedge clk_i); while (!req_if.ready);
    issued++;
  endtask

  // Lean toward adds or removals in stretches so the store keeps swinging
  // between empty and full.
  function automatic op_e pick_op(trend_e trend);
    int unsigned roll;
    roll = $urandom_range(0, 9);
    if (trend == TREND_GROW && roll < 6) begin
      case ($urandom_range(0, 2))
        0:       return OP_APPEND;
        1:       return OP_PREPEND;
        default: return OP_INSERT;
      endcase
    end
    if (trend == TREND_SHRINK && roll < 6) begin
      case ($urandom_range(0, 2))
        0:       return OP_DELETE_LAST;
        1:       return OP_DELETE_FST;
        default: return OP_DELETE_AT;
      endcase
    end
    return op_e'($urandom_range(0, 7));
  endfunction

  // Mostly in range, often exactly one past the last entry, sometimes anywhere.
  function automatic logic [POS_W-1:0] pick_position(int unsigned level);
    int unsigned roll;
    roll = $urandom_range(0, 19);
    if (roll < 13) return POS_W'($urandom_range(0, (level > 0) ? level - 1 : 0));
    if (roll < 17) return POS_W'(level);
    return POS_W'($urandom_range(0, 31));
  endfunction

  function automatic logic signed [DATA_W-1:0] pick_word();
    case ($urandom_range(0, 9))
      0:       return 32'sh8000_0000;
      1:       return 32'sh7fff_ffff;
      2:       return '0;
      3:       return -32'sd1;
      default: return $urandom;
    endcase
  endfunction

  // Response side: ready high in runs, broken by stall bursts while idling is on.
  initial begin
    rsp_if.ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      rsp_if.ready <= 1'b1;
      repeat ($urandom_range(1, 40)) @(posedge clk_i);
      if (sink_idles && !quiet_tail) begin
        rsp_if.ready <= 1'b0;
        repeat ($urandom_range(1, 17)) @(posedge clk_i);
      end
    end
  end

  // Watchdog: end the run if no transaction moves on either channel for too long.
  always @(posedge clk_i) begin
    if (!rst_ni || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("indexed_sequence_store verification failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    trend_e      trend;
    int unsigned stretch;
    req_if.valid     <= 1'b0;
    req_if.operation <= OP_APPEND;
    req_if.position  <= '0;
    req_if.data_word <= '0;
    rst_ni           <= 1'b0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed opening. Every remove, read and write on the empty store is refused,
    // as is an insert past the end.
    issue(OP_READ,        '0, $urandom);
    issue(OP_DELETE_LAST, POS_W'($urandom_range(0, 31)), $urandom);
    issue(OP_DELETE_FST,  POS_W'($urandom_range(0, 31)), $urandom);
    issue(OP_DELETE_AT,   '0, $urandom);
    issue(OP_WRITE,       '0, $urandom);
    issue(OP_INSERT,      POS_W'(1), $urandom);
    // Build up with the extreme words, inserting at the front, the end and the middle.
    issue(OP_INSERT,      '0, 32'sh8000_0000);
    issue(OP_APPEND,      POS_W'($urandom_range(0, 31)), 32'sh7fff_ffff);
    issue(OP_PREPEND,     POS_W'($urandom_range(0, 31)), -32'sd1);
    issue(OP_INSERT,      POS_W'(3), '0);
    issue(OP_INSERT,      POS_W'(1), 32'sh5a5a_5a5a);
    // Read the last entry, then one past it, at the largest index and at the capacity.
    issue(OP_READ,        POS_W'(4), $urandom);
    issue(OP_READ,        POS_W'(5), $urandom);
    issue(OP_READ,        POS_W'(31), $urandom);
    issue(OP_READ,        POS_W'(16), $urandom);
    issue(OP_WRITE,       POS_W'(2), 32'sh1234_5678);
    issue(OP_WRITE,       POS_W'(5), $urandom);
    issue(OP_DELETE_AT,   POS_W'(1), $urandom);
    issue(OP_DELETE_AT,   POS_W'(3), $urandom);
    issue(OP_DELETE_AT,   POS_W'(3), $urandom);
    issue(OP_DELETE_FST,  POS_W'($urandom_range(0, 31)), $urandom);
    issue(OP_DELETE_LAST, POS_W'($urandom_range(0, 31)), $urandom);
    issue(OP_DELETE_LAST, POS_W'($urandom_range(0, 31)), $urandom);

    // Random part in stretches, each with its own trend and idling mix.
    while (issued < RANDOM_ITEMS + 23) begin
      trend        = trend_e'($urandom_range(0, 2));
      stretch      = $urandom_range(8, 40);
      source_idles = ($urandom_range(0, 3) != 0);
      sink_idles   = ($urandom_range(0, 3) != 0);
      repeat (stretch) begin
        if (issued >= RANDOM_ITEMS + 23) break;
        quiet_tail = (issued + QUIET_ITEMS >= RANDOM_ITEMS + 23);
        issue(pick_op(trend), pick_position(fill), pick_word());
      end
    end
    req_if.valid <= 1'b0;

    // Drain: every prediction must be matched, then nothing more may arrive.
    wait (pending == 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Sent %0d requests and compared %0d responses.", issued, replies);
    $display("Requests seen on a full store: %0d, on an empty store: %0d.",
             full_hits, empty_hits);
    if (mismatches == 0 && pending == 0) begin
      $display("indexed_sequence_store verification clean");
    end else begin
      $display("indexed_sequence_store verification failed");
    end
    $finish;
  end

endmodule
